// File: hw/rtl/dsm_pkg.sv
`timescale 1ns / 1ps
package dsm_pkg;

  // Longest listing emitted for one input word
  localparam int MaxResults = 16;
  localparam int LenW       = $clog2(MaxResults + 1);

  typedef enum logic [2:0] {
    OP_PUSH1 = 3'd0,
    OP_PUSH2 = 3'd1,
    OP_POP1  = 3'd2,
    OP_POP2  = 3'd3,
    OP_PEEK1 = 3'd4,
    OP_PEEK2 = 3'd5,
    OP_LIST1 = 3'd6,
    OP_LIST2 = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic    take_push;
    logic    take_read;
    logic    pop;
    logic    list_start;
    logic    list_next;
    logic    emit_imm;
    status_t imm_status;
    logic    emit_mem;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic out_free;
    logic list_mode;
    logic list_done;
  } sts_t;

  // Odd codes address the stack that grows down from the top
  function automatic logic op_upper(op_t op);
    return op[0];
  endfunction

endpackage

// File: hw/rtl/dsm_ram.sv
`timescale 1ns / 1ps
module dsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/dsm_ctrl.sv
`timescale 1ns / 1ps
module dsm_ctrl import dsm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  op_t  op,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          unique case (op) inside
            OP_PUSH1, OP_PUSH2: begin
              cmd.take_push  = 1'b1;
              cmd.emit_imm   = 1'b1;
              cmd.imm_status = sts.full ? ST_OVERFLOW : ST_OK;
            end
            OP_POP1, OP_POP2, OP_PEEK1, OP_PEEK2: begin
              if (sts.empty) begin
                cmd.emit_imm   = 1'b1;
                cmd.imm_status = ST_EMPTY;
              end else begin
                cmd.take_read = 1'b1;
                cmd.pop       = (op == OP_POP1) || (op == OP_POP2);
                state_next    = S_READ;
              end
            end
            OP_LIST1, OP_LIST2: begin
              if (sts.empty) begin
                cmd.emit_imm   = 1'b1;
                cmd.imm_status = ST_EMPTY;
              end else begin
                cmd.list_start = 1'b1;
                state_next     = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        // read data is held in the RAM output until the result register frees up
        if (sts.out_free) begin
          cmd.emit_mem = 1'b1;
          if (sts.list_mode && !sts.list_done) begin
            cmd.list_next = 1'b1;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/dsm_datapath.sv
`timescale 1ns / 1ps
module dsm_datapath import dsm_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  op_t                op,
  input  logic signed [31:0] value,
  input  cmd_t               cmd,
  input  logic               out_ready,
  output sts_t               sts,
  output logic               out_valid,
  output logic signed [31:0] out_data,
  output status_t            out_status,
  output logic               out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [CW-1:0] TopC   = CW'(DEPTH - 1);

  logic [CW-1:0]         lower_count, upper_count;
  logic                  side_up, list_mode;
  logic [LenW-1:0]       list_idx, list_len;

  logic                  in_up, lst_up, full, empty, list_done, out_free;
  logic [CW-1:0]         in_count, push_addr, top_addr, list_addr, rd_addr_w, idx_w;
  logic [CW:0]           used;
  logic [LenW-1:0]       idx_next;
  logic                  wr_en, rd_en;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;

  assign in_up     = op_upper(op);
  assign in_count  = in_up ? upper_count : lower_count;
  assign used      = {1'b0, lower_count} + {1'b0, upper_count};
  assign full      = used >= {1'b0, DepthC};
  assign empty     = in_count == '0;
  assign list_done = LenW'(list_idx + LenW'(1)) == list_len;
  assign out_free  = !out_valid || out_ready;

  assign sts.full      = full;
  assign sts.empty     = empty;
  assign sts.out_free  = out_free;
  assign sts.list_mode = list_mode;
  assign sts.list_done = list_done;

  // addresses
  assign push_addr = in_up ? (TopC - upper_count) : lower_count;
  assign top_addr  = in_up ? (DepthC - upper_count) : (lower_count - CW'(1));
  assign idx_next  = cmd.list_start ? '0 : LenW'(list_idx + LenW'(1));
  assign idx_w     = CW'(idx_next);
  assign lst_up    = cmd.list_start ? in_up : side_up;
  assign list_addr = lst_up ? (TopC - idx_w) : idx_w;
  assign rd_addr_w = cmd.take_read ? top_addr : list_addr;

  assign wr_en   = cmd.take_push && !full;
  assign rd_en   = cmd.take_read || cmd.list_start || cmd.list_next;
  assign wr_data = DATA_WIDTH'($unsigned(value));

  dsm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (push_addr[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_w[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_count <= '0;
      upper_count <= '0;
      list_mode   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (wr_en) begin
        if (in_up) begin
          upper_count <= upper_count + CW'(1);
        end else begin
          lower_count <= lower_count + CW'(1);
        end
      end
      if (cmd.pop) begin
        if (in_up) begin
          upper_count <= upper_count - CW'(1);
        end else begin
          lower_count <= lower_count - CW'(1);
        end
      end
      if (cmd.take_read) begin
        list_mode <= 1'b0;
      end else if (cmd.list_start) begin
        list_mode <= 1'b1;
      end
      if (cmd.emit_imm || cmd.emit_mem) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_read || cmd.list_start) begin
      side_up <= in_up;
    end
    if (cmd.list_start) begin
      list_len <= (int'(in_count) < MaxResults) ? LenW'(in_count) : LenW'(MaxResults);
    end
    if (cmd.list_start || cmd.list_next) begin
      list_idx <= idx_next;
    end
    if (cmd.emit_imm) begin
      out_data   <= '0;
      out_status <= cmd.imm_status;
      out_last   <= 1'b1;
    end else if (cmd.emit_mem) begin
      out_data   <= 32'(rd_data);
      out_status <= ST_OK;
      out_last   <= list_mode ? list_done : 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_no_overcommit: assert property (@(posedge clk) disable iff (rst)
    used <= {1'b0, DepthC})
    else $error("stacks hold more words than the memory");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_imm || cmd.emit_mem) |-> out_free)
    else $error("result register overwritten before it was taken");

  a_list_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.list_next |-> (list_mode && !list_done))
    else $error("listing advanced past its length");

  a_full_push_noop: assert property (@(posedge clk) disable iff (rst)
    (cmd.take_push && full) |=> ($stable(lower_count) && $stable(upper_count)))
    else $error("push into full memory changed a stack count");
`endif

endmodule

// File: hw/rtl/dual_stack_shared_memory_unit.sv
`timescale 1ns / 1ps
// Two stacks in one RAM of DEPTH words: stack 1 grows up from address 0,
// stack 2 grows down from address DEPTH-1.
// Input channel (s_axis_*): one word per command. tuser = operation
// (push1, push2, pop1, pop2, peek1, peek2, list1, list2), tdata = value
// (used by push only, low DATA_WIDTH bits stored).
// Output channel (m_axis_*): tdata = data, tuser = status (ok, overflow,
// empty), tlast marks the final result word of a command.
// Push: one result word, registered in the cycle after accept; full memory
// gives overflow and no change. Pop/peek: one word through the registered
// RAM read and then the result register. List: up to 16 words bottom to
// top, the first through the same path, then one per cycle while m_axis_tready is high.
// Empty pop/peek/list gives a single empty-status word.
// Pushes can be taken back to back; pop/peek/list take no new command until
// their last word has entered the one-entry result register.
// A new command is taken when the result register is empty or being
// drained; a stalled receiver holds the result and stops input.
// Reset empties both stacks; RAM contents are not cleared.
module dual_stack_shared_memory_unit import dsm_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic signed [31:0] s_axis_tdata,   // [31:0] value
  input  logic [2:0]         s_axis_tuser,   // [2:0] operation
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic signed [31:0] m_axis_tdata,   // [31:0] data
  output logic [1:0]         m_axis_tuser,   // [1:0] status
  output logic               m_axis_tlast
);

  op_t     op;
  cmd_t    cmd;
  sts_t    sts;
  status_t out_status;

  assign op           = op_t'(s_axis_tuser);
  assign m_axis_tuser = out_status;

  // sequencer: decodes the command and steps through RAM reads
  dsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .op       (op),
    .sts      (sts),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  // stack counts, RAM, list counter and result register
  dsm_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .value      (s_axis_tdata),
    .cmd        (cmd),
    .out_ready  (m_axis_tready),
    .sts        (sts),
    .out_valid  (m_axis_tvalid),
    .out_data   (m_axis_tdata),
    .out_status (out_status),
    .out_last   (m_axis_tlast)
  );

endmodule

// File: verif/tb_dual_stack_shared_memory_unit.sv
`timescale 1ns / 1ps
module tb_dual_stack_shared_memory_unit;
  import dsm_pkg::*;

  localparam int DEPTH        = 16;
  localparam int DATA_WIDTH   = 32;
  localparam int RANDOM_WORDS = 420;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  // One result word as it leaves the block
  typedef struct packed {
    logic signed [31:0] data;
    status_t            status;
    logic               last;
  } result_word_t;

  // Directed row: op/value repeated reps times, value bumped per repeat.
  // pinned rows carry the expected result typed in; others use the predictor.
  typedef struct {
    op_t          op;
    logic [31:0]  value;
    int           reps;
    bit           pinned;
    result_word_t want;
  } stim_row_t;

  localparam result_word_t R_EMPTY = '{32'sd0, ST_EMPTY, 1'b1};
  localparam result_word_t R_OK    = '{32'sd0, ST_OK, 1'b1};
  localparam result_word_t R_OVF   = '{32'sd0, ST_OVERFLOW, 1'b1};

  localparam int N_ROWS = 23;
  stim_row_t directed_rows [N_ROWS] = '{
    // empty stacks right after reset
    '{OP_POP1,  32'h0000_0000, 1, 1'b1, R_EMPTY},
    '{OP_POP2,  32'h0000_0000, 1, 1'b1, R_EMPTY},
    '{OP_PEEK1, 32'hFFFF_FFFF, 1, 1'b1, R_EMPTY},
    '{OP_PEEK2, 32'hFFFF_FFFF, 1, 1'b1, R_EMPTY},
    '{OP_LIST1, 32'h0000_0000, 1, 1'b1, R_EMPTY},
    '{OP_LIST2, 32'h0000_0000, 1, 1'b1, R_EMPTY},
    // value extremes on both stacks
    '{OP_PUSH1, 32'h7FFF_FFFF, 1, 1'b1, R_OK},
    '{OP_PUSH2, 32'h8000_0000, 1, 1'b1, R_OK},
    '{OP_PEEK1, 32'h0000_0000, 1, 1'b0, R_OK},
    '{OP_PEEK2, 32'h0000_0000, 1, 1'b0, R_OK},
    '{OP_PUSH1, 32'hFFFF_FFFF, 1, 1'b1, R_OK},
    '{OP_PUSH2, 32'h0000_0000, 1, 1'b1, R_OK},
    '{OP_LIST1, 32'h0000_0000, 1, 1'b0, R_OK},
    '{OP_LIST2, 32'h0000_0000, 1, 1'b0, R_OK},
    '{OP_POP1,  32'h0000_0000, 1, 1'b0, R_OK},
    '{OP_POP2,  32'h0000_0000, 1, 1'b0, R_OK},
    // fill to the brim from both ends, then push into a full memory
    '{OP_PUSH1, 32'h5555_0000, 7, 1'b0, R_OK},
    '{OP_PUSH2, 32'hAAAA_0000, 7, 1'b0, R_OK},
    '{OP_PUSH1, 32'h1234_5678, 1, 1'b1, R_OVF},
    '{OP_PUSH2, 32'h8765_4321, 1, 1'b1, R_OVF},
    '{OP_LIST2, 32'h0000_0000, 1, 1'b0, R_OK},
    '{OP_POP1,  32'h0000_0000, 1, 1'b0, R_OK},
    '{OP_PEEK1, 32'h0000_0000, 1, 1'b0, R_OK}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic signed [31:0] s_axis_tdata = '0;  // [31:0] value
  logic [2:0]         s_axis_tuser = '0;  // [2:0] operation
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic signed [31:0] m_axis_tdata;       // [31:0] data
  logic [1:0]         m_axis_tuser;       // [1:0] status
  logic               m_axis_tlast;

  dual_stack_shared_memory_unit #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the two stacks
  logic [31:0]  shadow_mem [DEPTH];
  int unsigned  lower_depth = 0;
  int unsigned  upper_depth = 0;

  result_word_t pending_results [$];
  int           fail_count = 0;
  int           words_taken = 0;
  int           burst_left = 0;
  bit           hold_off_req = 1'b0;

  // Apply one accepted command to the shadow stacks and queue its results
  task automatic apply_stack_op(input op_t op, input logic [31:0] value,
                                input bit pinned, input result_word_t want);
    result_word_t outs [$];
    result_word_t w;
    int unsigned  cnt;
    int unsigned  n;
    int unsigned  addr;
    bit           upper;
    upper = op[0];
    cnt   = upper ? upper_depth : lower_depth;
    w     = R_OK;
    case (op)
      OP_PUSH1, OP_PUSH2: begin
        if (lower_depth + upper_depth >= DEPTH) begin
          w.status = ST_OVERFLOW;
        end else if (upper) begin
          upper_depth++;
          shadow_mem[DEPTH - upper_depth] = value;
        end else begin
          shadow_mem[lower_depth] = value;
          lower_depth++;
        end
        outs.push_back(w);
      end
      OP_POP1, OP_POP2, OP_PEEK1, OP_PEEK2: begin
        if (cnt == 0) begin
          w.status = ST_EMPTY;
        end else begin
          addr   = upper ? (DEPTH - cnt) : (cnt - 1);
          w.data = shadow_mem[addr];
          if (op == OP_POP1) lower_depth--;
          if (op == OP_POP2) upper_depth--;
        end
        outs.push_back(w);
      end
      default: begin
        if (cnt == 0) begin
          w.status = ST_EMPTY;
          outs.push_back(w);
        end else begin
          n = (cnt < MaxResults) ? cnt : MaxResults;
          for (int unsigned i = 0; i < n; i++) begin
            addr   = upper ? (DEPTH - 1 - i) : i;
            w.data = shadow_mem[addr];
            w.last = (i + 1 == n);
            outs.push_back(w);
          end
        end
      end
    endcase
    if (pinned) begin
      outs.delete();
      outs.push_back(want);
    end
    foreach (outs[k]) pending_results.push_back(outs[k]);
  endtask

  // Offer one command word in bursts with random gaps; returns on the
  // clock edge that takes it
  task automatic send_command(input op_t op, input logic [31:0] value,
                              input bit pinned, input result_word_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= value;
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
    words_taken++;
    apply_stack_op(op, value, pinned, want);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Stimulus
  initial begin
    int          scene;
    int          len;
    int          side;
    int unsigned n1;
    int unsigned n2;
    int          random_start;
    bit          hold_done;
    op_t         op;
    hold_done = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      for (int i = 0; i < directed_rows[r].reps; i++) begin
        send_command(directed_rows[r].op, directed_rows[r].value + i,
                     directed_rows[r].pinned, directed_rows[r].want);
      end
    end

    random_start = words_taken;
    while (words_taken - random_start < RANDOM_WORDS) begin
      if (!hold_done && words_taken - random_start > 150) begin
        hold_off_req = 1'b1;
        hold_done    = 1'b1;
      end
      scene = (words_taken == random_start) ? 6 : $urandom_range(0, 9);
      if (scene < 3) begin
        // push run on one or both stacks, often running into overflow
        side = $urandom_range(0, 2);
        len  = $urandom_range(1, 18);
        for (int k = 0; k < len; k++) begin
          if (side == 2) op = op_t'($urandom_range(0, 1));
          else op = side ? OP_PUSH2 : OP_PUSH1;
          send_command(op, pick_value(), 1'b0, R_OK);
        end
      end else if (scene < 5) begin
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          send_command(op_t'($urandom_range(2, 5)), pick_value(), 1'b0, R_OK);
        end
      end else if (scene == 5) begin
        op = $urandom_range(0, 1) ? OP_LIST2 : OP_LIST1;
        send_command(op, pick_value(), 1'b0, R_OK);
      end else if (scene == 6) begin
        // empty both stacks, fill one to full depth, list it, then push onto the other
        n1 = lower_depth;
        n2 = upper_depth;
        for (int unsigned k = 0; k < n1; k++)
          send_command(OP_POP1, pick_value(), 1'b0, R_OK);
        for (int unsigned k = 0; k < n2; k++)
          send_command(OP_POP2, pick_value(), 1'b0, R_OK);
        side = $urandom_range(0, 1);
        for (int k = 0; k < DEPTH; k++)
          send_command(side ? OP_PUSH2 : OP_PUSH1, pick_value(), 1'b0, R_OK);
        send_command(side ? OP_LIST2 : OP_LIST1, pick_value(), 1'b0, R_OK);
        send_command(side ? OP_PUSH1 : OP_PUSH2, pick_value(), 1'b0, R_OK);
      end else begin
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++) begin
          send_command(op_t'($urandom_range(0, 7)), pick_value(), 1'b0, R_OK);
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver: rotating stall pattern, plus one long hold-off while the
  // sender keeps sending so the block backs up into its input
  initial begin
    logic [15:0] ready_pattern;
    int          age;
    ready_pattern = 16'hFFFF;
    age           = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      if (age == 0) begin
        age = $urandom_range(32, 96);
        case ($urandom_range(0, 3))
          0:       ready_pattern = 16'hFFFF;
          1:       ready_pattern = 16'h0101;
          default: ready_pattern = $urandom;
        endcase
        if (ready_pattern == 16'h0000) ready_pattern = 16'h8421;
      end
      age--;
      m_axis_tready <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      @(posedge clk);
    end
  end

  // Result checker: sampled mid-cycle, so the word moves at the next edge
  always @(negedge clk) begin
    result_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: data %h status %0d last %0b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.data) begin
          $error("data: expected %h, got %h", want.data, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #(64'd5_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: dual_stack_shared_memory_unit.f
hw/rtl/dsm_pkg.sv
hw/rtl/dsm_ram.sv
hw/rtl/dsm_ctrl.sv
hw/rtl/dsm_datapath.sv
hw/rtl/dual_stack_shared_memory_unit.sv
verif/tb_dual_stack_shared_memory_unit.sv
